[hw/rtl/hsm_pkg.sv]
// Shared types and constants for the hierarchical state machine engine.
package hsm_pkg;

	localparam int STATE_W   = 4;
	localparam int NUM_STATES = 16;
	localparam int MAX_DEPTH = 4;
	localparam int SLOTS     = 4;
	localparam int BUF_LEN   = 3 * MAX_DEPTH + 1;
	localparam int TR_W      = 14;

	localparam logic [4:0] NO_SUB = 5'd16;

	localparam logic [2:0] OP_EVENT   = 3'd0;
	localparam logic [2:0] OP_RESTART = 3'd1;
	localparam logic [2:0] OP_OWNER   = 3'd2;
	localparam logic [2:0] OP_INFO    = 3'd3;
	localparam logic [2:0] OP_TRANS   = 3'd4;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_ENTRY = 2'd1;
	localparam logic [1:0] ACT_EXIT  = 2'd2;
	localparam logic [1:0] ACT_TRANS = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  event_code;
		logic [15:0] guard_true;
		logic [3:0]  state_index;
		logic [1:0]  slot_index;
		logic [3:0]  ref_state;
		logic [2:0]  owner_count;
		logic [4:0]  initial_sub;
		logic        has_guard;
		logic        has_entry;
		logic        has_exit;
		logic        has_action;
	} in_item_t;

	typedef struct packed {
		logic [1:0] action_kind;
		logic [3:0] action_state;
		logic [1:0] action_slot;
		logic       fired;
		logic [3:0] new_state;
		logic       table_error;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] st;
		logic [1:0] slot;
	} act_t;

	typedef struct packed {
		logic [STATE_W-1:0]   own_addr;
		logic [STATE_W-1:0]   sub_addr;
		logic [STATE_W-1:0]   flag_addr;
		logic [STATE_W-1:0]   tr_state;
		logic [1:0]           tr_slot;
	} tab_rd_t;

	typedef struct packed {
		logic [STATE_W*MAX_DEPTH-1:0] own_row;
		logic [2:0]                   own_len;
		logic [4:0]                   sub;
		logic [1:0]                   flags;
		logic [TR_W-1:0]              tr;
	} tab_data_t;

	function automatic logic [3:0] nib(input logic [15:0] row, input logic [1:0] idx);
		return row[idx*4 +: 4];
	endfunction

	function automatic logic is_owner(input logic [3:0] s, input logic [15:0] row,
		input logic [2:0] len);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (i < int'(len) && row[i*4 +: 4] == s)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

[hw/rtl/hsm_tables.sv]
// State, owner and transition tables with one read address per table.
module hsm_tables (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  hsm_pkg::in_item_t wr,
	input  hsm_pkg::tab_rd_t  rd,
	output hsm_pkg::tab_data_t data
);

	logic [15:0] own_q [hsm_pkg::NUM_STATES];
	logic [2:0]  len_q [hsm_pkg::NUM_STATES];
	logic [4:0]  sub_q [hsm_pkg::NUM_STATES];
	logic [1:0]  flag_q [hsm_pkg::NUM_STATES];
	logic [hsm_pkg::TR_W*hsm_pkg::SLOTS-1:0] tr_q [hsm_pkg::NUM_STATES];

	logic [2:0] cnt_clip;
	logic [4:0] sub_clip;

	always_comb begin
		cnt_clip = wr.owner_count;
		if (cnt_clip == 3'd0)
			cnt_clip = 3'd1;
		if (cnt_clip > 3'(hsm_pkg::MAX_DEPTH))
			cnt_clip = 3'(hsm_pkg::MAX_DEPTH);
		sub_clip = (wr.initial_sub > 5'd15) ? hsm_pkg::NO_SUB : wr.initial_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hsm_pkg::NUM_STATES; i++) begin
				own_q[i]  <= '0;
				len_q[i]  <= 3'd1;
				sub_q[i]  <= hsm_pkg::NO_SUB;
				flag_q[i] <= '0;
				tr_q[i]   <= '0;
			end
		end else if (we) begin
			case (wr.operation)
				hsm_pkg::OP_OWNER: begin
					own_q[wr.state_index][wr.slot_index*4 +: 4] <= wr.ref_state;
				end
				hsm_pkg::OP_INFO: begin
					len_q[wr.state_index]  <= cnt_clip;
					sub_q[wr.state_index]  <= sub_clip;
					flag_q[wr.state_index] <= {wr.has_exit, wr.has_entry};
				end
				hsm_pkg::OP_TRANS: begin
					tr_q[wr.state_index][wr.slot_index*hsm_pkg::TR_W +: hsm_pkg::TR_W] <=
						{wr.has_action, wr.has_guard, wr.ref_state, wr.event_code};
				end
				default: begin
				end
			endcase
		end
	end

	assign data.own_row = own_q[rd.own_addr];
	assign data.own_len = len_q[rd.own_addr];
	assign data.sub     = sub_q[rd.sub_addr];
	assign data.flags   = flag_q[rd.flag_addr];
	assign data.tr      = tr_q[rd.tr_state][rd.tr_slot*hsm_pkg::TR_W +: hsm_pkg::TR_W];

endmodule

[hw/rtl/hierarchical_state_machine_engine.sv]
// Top level: sequencer that walks the tables and buffers the actions of one request.
// An event searches up to 16 transition slots and, when one fires, drills down to the target
// and walks the exit and entry owner levels, plus the start drill-down and entry walk when it
// is the first event. Each result then waits on out_ready; one request is in work at a time.
// Reset is asynchronous: tables return to their defaults, the machine is not started.
module hierarchical_state_machine_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hsm_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DRILL = 4'd1;
	localparam logic [3:0] S_LOADT = 4'd2;
	localparam logic [3:0] S_SENT  = 4'd3;
	localparam logic [3:0] S_CINIT = 4'd4;
	localparam logic [3:0] S_SRCH  = 4'd5;
	localparam logic [3:0] S_EXIT  = 4'd6;
	localparam logic [3:0] S_TACT  = 4'd7;
	localparam logic [3:0] S_ENT   = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;
	localparam logic [3:0] S_WAIT  = 4'd10;

	logic [3:0]  state_q;
	logic [3:0]  init_q;
	logic [3:0]  active_q;
	logic        started_q;
	logic [2:0]  op_q;
	logic [7:0]  ev_q;
	logic [15:0] guard_q;
	logic [3:0]  cur_q;
	logic [2:0]  dk_q;
	logic        mode_start_q;
	logic [3:0]  tgt_q;
	logic [15:0] tgt_row_q;
	logic [2:0]  tgt_len_q;
	logic [15:0] src_row_q;
	logic [2:0]  src_len_q;
	logic [1:0]  j_q;
	logic [1:0]  i_q;
	logic [3:0]  own_q;
	logic [1:0]  slot_q;
	logic        tact_q;
	logic        fired_q;
	logic        err_q;
	logic [3:0]  cnt_q;
	logic [3:0]  rd_q;
	logic        out_valid_q;
	hsm_pkg::out_item_t out_q;
	hsm_pkg::act_t      buf_q [hsm_pkg::BUF_LEN];

	hsm_pkg::tab_rd_t   trd;
	hsm_pkg::tab_data_t tdat;
	logic               accept;
	logic [1:0]         tgt_idx;
	logic [3:0]         s_sel;
	logic               push;
	hsm_pkg::act_t      push_act;
	logic               hit;
	logic               last_res;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	hsm_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (accept),
		.wr     (in_data),
		.rd     (trd),
		.data   (tdat)
	);

	always_comb begin
		tgt_idx = 2'(tgt_len_q - 3'd1 - {1'b0, j_q});
		s_sel   = (state_q == S_EXIT) ? hsm_pkg::nib(src_row_q, j_q)
			: hsm_pkg::nib(tgt_row_q, tgt_idx);
		trd.own_addr  = (state_q == S_CINIT) ? active_q : tgt_q;
		trd.sub_addr  = cur_q;
		trd.flag_addr = s_sel;
		trd.tr_state  = hsm_pkg::nib(src_row_q, j_q);
		trd.tr_slot   = i_q;
		hit = (tdat.tr[7:0] == ev_q) && (!tdat.tr[12] || guard_q[{j_q, i_q}]);
		push     = 1'b0;
		push_act = '0;
		case (state_q)
			S_SENT: begin
				push = tdat.flags[0];
				push_act = '{kind: hsm_pkg::ACT_ENTRY, st: s_sel, slot: 2'd0};
			end
			S_EXIT: begin
				push = tdat.flags[1] && !hsm_pkg::is_owner(s_sel, tgt_row_q, tgt_len_q);
				push_act = '{kind: hsm_pkg::ACT_EXIT, st: s_sel, slot: 2'd0};
			end
			S_TACT: begin
				push = tact_q;
				push_act = '{kind: hsm_pkg::ACT_TRANS, st: own_q, slot: slot_q};
			end
			S_ENT: begin
				push = tdat.flags[0] && !hsm_pkg::is_owner(s_sel, src_row_q, src_len_q);
				push_act = '{kind: hsm_pkg::ACT_ENTRY, st: s_sel, slot: 2'd0};
			end
			default: begin
			end
		endcase
		last_res = (cnt_q == 4'd0) || (rd_q == cnt_q - 4'd1);
	end

	always_ff @(posedge clk) begin
		if (push && cnt_q < 4'(hsm_pkg::BUF_LEN))
			buf_q[cnt_q] <= push_act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			init_q       <= '0;
			active_q     <= '0;
			started_q    <= 1'b0;
			cnt_q        <= '0;
			rd_q         <= '0;
			out_valid_q  <= 1'b0;
			fired_q      <= 1'b0;
			err_q        <= 1'b0;
			j_q          <= '0;
			i_q          <= '0;
			dk_q         <= '0;
			mode_start_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				init_q <= cfg_data;
			if (push && cnt_q < 4'(hsm_pkg::BUF_LEN))
				cnt_q <= cnt_q + 4'd1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= in_data.operation;
						ev_q    <= in_data.event_code;
						guard_q <= in_data.guard_true;
						cnt_q   <= '0;
						rd_q    <= '0;
						err_q   <= 1'b0;
						fired_q <= 1'b0;
						cur_q   <= init_q;
						dk_q    <= '0;
						mode_start_q <= 1'b1;
						if (in_data.operation == hsm_pkg::OP_RESTART) begin
							started_q <= 1'b0;
							state_q <= S_DRILL;
						end else if (in_data.operation == hsm_pkg::OP_EVENT) begin
							state_q <= started_q ? S_CINIT : S_DRILL;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_DRILL: begin
					if (tdat.sub != hsm_pkg::NO_SUB && dk_q < 3'(hsm_pkg::MAX_DEPTH)) begin
						cur_q <= tdat.sub[3:0];
						dk_q  <= dk_q + 3'd1;
					end else begin
						if (tdat.sub != hsm_pkg::NO_SUB)
							err_q <= 1'b1;
						tgt_q   <= cur_q;
						state_q <= S_LOADT;
					end
				end
				S_LOADT: begin
					tgt_row_q <= tdat.own_row;
					tgt_len_q <= tdat.own_len;
					j_q <= '0;
					if (mode_start_q) begin
						active_q <= tgt_q;
						state_q  <= S_SENT;
					end else begin
						state_q <= S_EXIT;
					end
				end
				S_SENT: begin
					if ({1'b0, j_q} == tgt_len_q - 3'd1) begin
						started_q <= 1'b1;
						state_q <= (op_q == hsm_pkg::OP_EVENT) ? S_CINIT : S_EMIT;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				S_CINIT: begin
					src_row_q <= tdat.own_row;
					src_len_q <= tdat.own_len;
					j_q <= '0;
					i_q <= '0;
					state_q <= (ev_q == 8'd0) ? S_EMIT : S_SRCH;
				end
				S_SRCH: begin
					if (hit) begin
						fired_q <= 1'b1;
						own_q   <= hsm_pkg::nib(src_row_q, j_q);
						slot_q  <= i_q;
						tact_q  <= tdat.tr[13];
						cur_q   <= tdat.tr[11:8];
						dk_q    <= '0;
						mode_start_q <= 1'b0;
						state_q <= S_DRILL;
					end else if (i_q == 2'(hsm_pkg::SLOTS - 1)) begin
						i_q <= '0;
						if ({1'b0, j_q} == src_len_q - 3'd1)
							state_q <= S_EMIT;
						else
							j_q <= j_q + 2'd1;
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				S_EXIT: begin
					if ({1'b0, j_q} == src_len_q - 3'd1)
						state_q <= S_TACT;
					else
						j_q <= j_q + 2'd1;
				end
				S_TACT: begin
					active_q <= tgt_q;
					j_q <= '0;
					state_q <= S_ENT;
				end
				S_ENT: begin
					if ({1'b0, j_q} == tgt_len_q - 3'd1)
						state_q <= S_EMIT;
					else
						j_q <= j_q + 2'd1;
				end
				S_EMIT: begin
					if (cnt_q == 4'd0) begin
						out_q.action_kind  <= hsm_pkg::ACT_NONE;
						out_q.action_state <= '0;
						out_q.action_slot  <= '0;
					end else begin
						out_q.action_kind  <= buf_q[rd_q].kind;
						out_q.action_state <= buf_q[rd_q].st;
						out_q.action_slot  <= buf_q[rd_q].slot;
					end
					out_q.fired       <= fired_q;
					out_q.new_state   <= active_q;
					out_q.table_error <= err_q;
					out_q.last        <= last_res;
					out_valid_q <= 1'b1;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_q.last) begin
							state_q <= S_IDLE;
						end else begin
							rd_q <= rd_q + 4'd1;
							state_q <= S_EMIT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result is only presented while the sequencer waits for it to be taken.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> state_q == S_WAIT)
		else $error("result valid outside the output wait state");
	// The action buffer never grows past its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(hsm_pkg::BUF_LEN))
		else $error("action buffer overrun");
	// A taken last result returns the sequencer to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last |=> in_ready)
		else $error("not idle after the last result");
	// A request without a fired transition reports no transition action.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.fired |-> out_data.action_kind != hsm_pkg::ACT_TRANS)
		else $error("transition action without a fired transition");
`endif

endmodule

[test/hsm_checker.sv]
// Checker for the hierarchical state machine engine: predicts actions per request and compares.
module hsm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  hsm_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  hsm_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	output int                 fail_count,
	output int                 pending_actions
);

	logic [3:0]  home_state;
	logic [3:0]  own_tab [16][4];
	logic [2:0]  own_len [16];
	logic [4:0]  sub_tab [16];
	logic [1:0]  flag_tab [16];
	logic [13:0] tr_tab [16][4];
	logic [3:0]  active;
	logic        running;

	hsm_pkg::out_item_t action_queue[$];
	hsm_pkg::act_t      acts[$];
	logic               drill_err;

	assign pending_actions = action_queue.size();

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic logic [3:0] drill(input logic [3:0] s);
		logic [3:0] cur;
		cur = s;
		for (int k = 0; k < hsm_pkg::MAX_DEPTH; k++)
			if (sub_tab[cur] != hsm_pkg::NO_SUB)
				cur = sub_tab[cur][3:0];
		if (sub_tab[cur] != hsm_pkg::NO_SUB)
			drill_err = 1'b1;
		return cur;
	endfunction

	function automatic logic owns(input logic [3:0] s, input logic [3:0] of);
		for (int i = 0; i < own_len[of]; i++)
			if (own_tab[of][i] == s)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void push_act(input logic [1:0] k, input logic [3:0] s,
		input logic [1:0] sl);
		hsm_pkg::act_t a;
		a.kind = k;
		a.st = s;
		a.slot = sl;
		acts.push_back(a);
	endfunction

	function automatic void start_machine();
		logic [3:0] a;
		int n;
		a = drill(home_state);
		active = a;
		n = own_len[a];
		for (int j = 0; j < n; j++)
			if (flag_tab[own_tab[a][n-1-j]][0])
				push_act(hsm_pkg::ACT_ENTRY, own_tab[a][n-1-j], 2'd0);
		running = 1'b1;
	endfunction

	function automatic logic take_event(input logic [7:0] ev, input logic [15:0] guard);
		logic [3:0] src, owner, tgt, s;
		logic [1:0] slot;
		logic [13:0] t, c;
		logic found, ok;
		int sn, tn, bitn;
		src = active;
		sn = own_len[src];
		found = 1'b0;
		owner = '0;
		slot = '0;
		t = '0;
		if (ev == 8'd0)
			return 1'b0;
		for (int j = 0; j < sn && !found; j++) begin
			for (int i = 0; i < hsm_pkg::SLOTS && !found; i++) begin
				c = tr_tab[own_tab[src][j]][i];
				bitn = j * 4 + i;
				ok = !c[12] || (bitn < 16 && guard[bitn]);
				if (c[7:0] == ev && ok) begin
					found = 1'b1;
					t = c;
					owner = own_tab[src][j];
					slot = i[1:0];
				end
			end
		end
		if (!found)
			return 1'b0;
		tgt = drill(t[11:8]);
		tn = own_len[tgt];
		for (int j = 0; j < sn; j++) begin
			s = own_tab[src][j];
			if (flag_tab[s][1] && !owns(s, tgt))
				push_act(hsm_pkg::ACT_EXIT, s, 2'd0);
		end
		if (t[13])
			push_act(hsm_pkg::ACT_TRANS, owner, slot);
		active = tgt;
		for (int j = 0; j < tn; j++) begin
			s = own_tab[tgt][tn-1-j];
			if (flag_tab[s][0] && !owns(s, src))
				push_act(hsm_pkg::ACT_ENTRY, s, 2'd0);
		end
		return 1'b1;
	endfunction

	function automatic void predict_request(input hsm_pkg::in_item_t r);
		logic fired;
		logic [2:0] cnt;
		hsm_pkg::out_item_t o;
		acts.delete();
		drill_err = 1'b0;
		fired = 1'b0;
		case (r.operation)
			hsm_pkg::OP_EVENT: begin
				if (!running)
					start_machine();
				fired = take_event(r.event_code, r.guard_true);
			end
			hsm_pkg::OP_RESTART: begin
				running = 1'b0;
				start_machine();
			end
			hsm_pkg::OP_OWNER: own_tab[r.state_index][r.slot_index] = r.ref_state;
			hsm_pkg::OP_INFO: begin
				cnt = r.owner_count;
				if (cnt < 3'd1)
					cnt = 3'd1;
				if (cnt > 3'(hsm_pkg::MAX_DEPTH))
					cnt = 3'(hsm_pkg::MAX_DEPTH);
				own_len[r.state_index] = cnt;
				sub_tab[r.state_index] = (r.initial_sub > 5'd15) ? hsm_pkg::NO_SUB
					: r.initial_sub;
				flag_tab[r.state_index] = {r.has_exit, r.has_entry};
			end
			hsm_pkg::OP_TRANS: tr_tab[r.state_index][r.slot_index] = {r.has_action,
				r.has_guard, r.ref_state, r.event_code};
			default: ;
		endcase
		if (acts.size() == 0)
			push_act(hsm_pkg::ACT_NONE, 4'd0, 2'd0);
		foreach (acts[k]) begin
			o.action_kind = acts[k].kind;
			o.action_state = acts[k].st;
			o.action_slot = acts[k].slot;
			o.fired = fired;
			o.new_state = active;
			o.table_error = drill_err;
			o.last = (k == acts.size() - 1);
			action_queue.push_back(o);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_state = '0;
			active = '0;
			running = 1'b0;
			fail_count = 0;
			for (int s = 0; s < 16; s++) begin
				own_len[s] = 3'd1;
				sub_tab[s] = hsm_pkg::NO_SUB;
				flag_tab[s] = '0;
				for (int i = 0; i < 4; i++) begin
					own_tab[s][i] = '0;
					tr_tab[s][i] = '0;
				end
			end
			action_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				home_state = cfg_data;
			if (out_valid && out_ready) begin
				if (action_queue.size() == 0)
					report_mismatch("action with no request pending");
				else begin
					hsm_pkg::out_item_t e;
					e = action_queue.pop_front();
					if (out_data.action_kind !== e.action_kind)
						report_mismatch($sformatf("action_kind %0d exp %0d",
							out_data.action_kind, e.action_kind));
					if (out_data.action_state !== e.action_state)
						report_mismatch($sformatf("action_state %0d exp %0d",
							out_data.action_state, e.action_state));
					if (out_data.action_slot !== e.action_slot)
						report_mismatch($sformatf("action_slot %0d exp %0d",
							out_data.action_slot, e.action_slot));
					if (out_data.fired !== e.fired)
						report_mismatch($sformatf("fired %0d exp %0d",
							out_data.fired, e.fired));
					if (out_data.new_state !== e.new_state)
						report_mismatch($sformatf("new_state %0d exp %0d",
							out_data.new_state, e.new_state));
					if (out_data.table_error !== e.table_error)
						report_mismatch($sformatf("table_error %0d exp %0d",
							out_data.table_error, e.table_error));
					if (out_data.last !== e.last)
						report_mismatch($sformatf("last %0d exp %0d",
							out_data.last, e.last));
				end
			end
			if (in_valid && in_ready)
				predict_request(in_data);
		end
	end

endmodule

[test/tb_hierarchical_state_machine_engine.sv]
// Testbench top: drives requests and configuration into the engine and gives the verdict.
module tb_hierarchical_state_machine_engine;

	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      in_valid, in_ready;
	hsm_pkg::in_item_t  in_data;
	logic      out_valid, out_ready;
	hsm_pkg::out_item_t out_data;
	logic      cfg_valid, cfg_ready;
	logic [3:0] cfg_data;
	int        fail_count, pending_actions;
	logic      quiet;

	hierarchical_state_machine_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	hsm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_actions(pending_actions)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver stalls in bursts until the quiet tail of the run.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	// Valid stays up across back-to-back requests; it drops only for an idle gap or a drain.
	task automatic send_request(input hsm_pkg::in_item_t r);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_actions();
		in_valid <= 1'b0;
		while (pending_actions != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_home(input logic [3:0] v);
		drain_actions();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic hsm_pkg::in_item_t noise_item();
		hsm_pkg::in_item_t r;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		r = raw[$bits(hsm_pkg::in_item_t)-1:0];
		return r;
	endfunction

	function automatic hsm_pkg::in_item_t make_item(input logic [2:0] op,
		input logic [7:0] ev, input logic [3:0] st, input logic [1:0] sl,
		input logic [3:0] rs, input logic [2:0] cnt, input logic [4:0] sub);
		hsm_pkg::in_item_t r;
		r = noise_item();
		r.operation = op;
		r.event_code = ev;
		r.state_index = st;
		r.slot_index = sl;
		r.ref_state = rs;
		r.owner_count = cnt;
		r.initial_sub = sub;
		return r;
	endfunction

	// A random table in which owner lists are real ancestor chains.
	task automatic build_tree();
		hsm_pkg::in_item_t r;
		logic [3:0] parent [16];
		logic [3:0] cur;
		int depth;
		for (int s = 0; s < 16; s++) begin
			parent[s] = (s == 0) ? 4'd0 : 4'($urandom_range(0, s - 1));
			cur = s[3:0];
			depth = 0;
			while (depth < 4) begin
				send_request(make_item(hsm_pkg::OP_OWNER, '0, s[3:0], depth[1:0], cur,
					'0, '0));
				depth++;
				if (cur == 4'd0)
					break;
				cur = parent[cur];
			end
			r = make_item(hsm_pkg::OP_INFO, '0, s[3:0], '0, '0, 3'(depth),
				($urandom_range(0, 2) == 0) ? 5'($urandom_range(s, 15)) : hsm_pkg::NO_SUB);
			send_request(r);
		end
		for (int k = 0; k < 24; k++)
			send_request(make_item(hsm_pkg::OP_TRANS, 8'($urandom_range(1, 6)),
				4'($urandom), 2'($urandom), 4'($urandom), '0, '0));
	endtask

	initial begin
		hsm_pkg::in_item_t r;
		quiet = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: first event starts with event zero, edge values, bad operations.
		send_request(make_item(hsm_pkg::OP_EVENT, 8'd0, '0, '0, '0, 3'd1, '0));
		send_request(make_item(hsm_pkg::OP_INFO, '0, 4'd3, '0, '0, 3'd0, 5'd31));
		send_request(make_item(hsm_pkg::OP_INFO, '0, 4'd15, '0, 4'd0, 3'd7, 5'd14));
		send_request(make_item(hsm_pkg::OP_INFO, '0, 4'd14, '0, '0, 3'd2, 5'd13));
		send_request(make_item(hsm_pkg::OP_INFO, '0, 4'd13, '0, '0, 3'd1, 5'd12));
		send_request(make_item(hsm_pkg::OP_INFO, '0, 4'd12, '0, '0, 3'd1, 5'd11));
		send_request(make_item(hsm_pkg::OP_INFO, '0, 4'd11, '0, '0, 3'd1, 5'd10));
		send_request(make_item(hsm_pkg::OP_OWNER, '0, 4'd15, 2'd3, 4'd15, '0, '0));
		r = make_item(hsm_pkg::OP_TRANS, 8'd255, 4'd0, 2'd3, 4'd15, '0, '0);
		r.has_guard = 1'b1;
		r.has_action = 1'b1;
		send_request(r);
		send_request(make_item(OP_UNUSED_LO, 8'd255, '0, '0, '0, '0, '0));
		send_request(make_item(OP_UNUSED_HI, 8'd255, '0, '0, '0, '0, '0));
		r = make_item(hsm_pkg::OP_EVENT, 8'd255, '0, '0, '0, '0, '0);
		r.guard_true = 16'h0000;
		send_request(r);
		r.guard_true = 16'hFFFF;
		send_request(r);
		write_home(4'd15);
		send_request(make_item(hsm_pkg::OP_RESTART, '0, '0, '0, '0, '0, '0));
		write_home(4'd0);
		send_request(make_item(hsm_pkg::OP_RESTART, '0, '0, '0, '0, '0, '0));

		// Random: a well-formed table with event bursts, plus noise.
		for (int round = 0; round < 2; round++) begin
			write_home(round == 1 ? 4'd15 : 4'($urandom));
			if (round == 0)
				build_tree();
			send_request(make_item(hsm_pkg::OP_RESTART, '0, '0, '0, '0, '0, '0));
			if (round == 1)
				quiet = 1'b1;
			for (int k = 0; k < 30; k++) begin
				if ($urandom_range(0, 9) == 0)
					r = noise_item();
				else begin
					r = noise_item();
					r.operation = hsm_pkg::OP_EVENT;
					r.event_code = 8'($urandom_range(0, 7));
				end
				send_request(r);
			end
		end

		drain_actions();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
